>>> src/first_fit_page_region_allocator_top_assert.svh
// Assertion macros for the page region allocator.
// Depends on nothing; included by modules that check their own logic.
`ifndef FIRST_FIT_PAGE_REGION_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_PAGE_REGION_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FFPRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ffpra_pkg.sv
// Shared types and constants of the page region allocator.
// No dependencies.
package ffpra_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam logic [32:0] PAGE_ROUND = 33'd4095;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_POOL_BASE  = 2'd0,
        CFG_POOL_BYTES = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHK,
        S_MOVE
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] request_bytes;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] region_address;
        logic [19:0] freed_first_page;
        logic [20:0] freed_page_count;
        logic        legitimate;
    } t_rsp;

    typedef struct packed {
        logic [19:0] base_pg;
        logic [20:0] page_total;
    } t_entry;

endpackage

>>> src/ffpra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/first_fit_page_region_allocator_top.sv
// A word is accepted in S_IDLE; S_RD finishes check and unused kinds. Alloc and
// release alternate S_RD and S_CHK per table entry scanned: a miss ends in S_RD,
// a hit or a full table in S_CHK, a slot compaction in S_MOVE. One word in flight;
// a new word may be accepted in the o_done cycle, so throughput is set by the serial scan.
// Reset (sync, active low) and any pool register write rebuild both tables in
// S_INIT (busy high). Results strobe on o_done for one cycle; no backpressure.
module first_fit_page_region_allocator_top #(
    parameter int REGION_SLOTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ffpra_pkg::t_req  i_req,
    output logic             o_done,
    output ffpra_pkg::t_rsp  o_rsp,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data
);
    import ffpra_pkg::*;

    `include "first_fit_page_region_allocator_top_assert.svh"

    localparam int IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS = CW'(REGION_SLOTS);
    localparam int EW = $bits(t_entry);

    // configuration registers
    logic [31:0] r_base, r_bytes;

    // control
    t_state      r_state, n_state;
    logic [CW-1:0] r_f_cnt, n_f_cnt, r_u_cnt, n_u_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic        r_done, n_done;
    t_rsp        r_rsp, n_rsp;

    // latched word
    t_kind       r_kind;
    logic [20:0] r_pages;
    logic [19:0] r_sp;
    logic [31:0] r_addr;

    // table RAM ports
    logic          f_we, u_we;
    logic [IW-1:0] f_wa, u_wa, f_ra, u_ra;
    t_entry        f_wd, u_wd, f_rd, u_rd;

    logic [32:0] round_sum;
    logic [20:0] rem;
    logic [19:0] pool_pages;
    logic        cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_POOL_BASE || i_cfg_idx == CFG_POOL_BYTES);

    ffpra_ram #(.WIDTH(EW), .DEPTH(REGION_SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_wa),
        .i_wdata (f_wd),
        .i_raddr (f_ra),
        .o_rdata (f_rd)
    );

    ffpra_ram #(.WIDTH(EW), .DEPTH(REGION_SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_wa),
        .i_wdata (u_wd),
        .i_raddr (u_ra),
        .o_rdata (u_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 32'h4000_0000;
            r_bytes <= 32'h0040_0000;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_POOL_BASE) begin
                r_base <= i_cfg_data;
            end else if (i_cfg_idx == CFG_POOL_BYTES) begin
                r_bytes <= i_cfg_data;
            end
        end
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_f_cnt <= '0;
            r_u_cnt <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= cfg_hit ? S_INIT : n_state;
            r_f_cnt <= n_f_cnt;
            r_u_cnt <= n_u_cnt;
            r_idx   <= n_idx;
            r_done  <= n_done;
        end
    end

    // payload, no reset
    assign round_sum = {1'b0, i_req.request_bytes} + PAGE_ROUND;

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (start && !busy) begin
            r_kind  <= i_req.kind;
            r_pages <= round_sum[32:PAGE_SHIFT];
            r_sp    <= i_req.address[31:PAGE_SHIFT];
            r_addr  <= i_req.address;
        end
    end

    assign pool_pages = r_bytes[31:PAGE_SHIFT];
    assign rem = f_rd.page_total - r_pages;

    always_comb begin
        n_state = r_state;
        n_f_cnt = r_f_cnt;
        n_u_cnt = r_u_cnt;
        n_idx   = r_idx;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        f_we = 1'b0;
        u_we = 1'b0;
        f_wa = r_idx[IW-1:0];
        u_wa = r_idx[IW-1:0];
        f_wd = f_rd;
        u_wd = u_rd;
        f_ra = r_idx[IW-1:0];
        u_ra = r_idx[IW-1:0];

        unique case (r_state)
            S_INIT: begin
                // rebuild: first pool page allocated, the rest free
                f_we = 1'b1;
                u_we = 1'b1;
                f_wa = '0;
                u_wa = '0;
                f_wd.base_pg = r_base[31:PAGE_SHIFT] + 20'd1;
                f_wd.page_total = {1'b0, pool_pages} - 21'd1;
                u_wd.base_pg = r_base[31:PAGE_SHIFT];
                u_wd.page_total = 21'd1;
                n_u_cnt = CW'(1);
                n_f_cnt = (pool_pages >= 20'd2) ? CW'(1) : '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_idx   = '0;
                    n_rsp   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                case (r_kind)
                    KIND_ALLOC: begin
                        if (r_idx >= r_f_cnt) begin
                            n_rsp.status = ST_NO_FIT;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_CHK;
                        end
                    end
                    KIND_RELEASE: begin
                        if (r_idx >= r_u_cnt) begin
                            n_rsp.status = ST_NOT_FOUND;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_CHK;
                        end
                    end
                    KIND_CHECK: begin
                        n_rsp.legitimate = ({1'b0, r_addr} >= {1'b0, r_base}) &&
                            ({1'b0, r_addr} < ({1'b0, r_base} + {1'b0, r_bytes}));
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CHK: begin
                if (r_kind == KIND_ALLOC) begin
                    if (f_rd.page_total >= r_pages) begin
                        if (r_u_cnt >= SLOTS) begin
                            n_rsp.status = ST_FULL;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            u_we = 1'b1;
                            u_wa = r_u_cnt[IW-1:0];
                            u_wd.base_pg = f_rd.base_pg;
                            u_wd.page_total = r_pages;
                            n_u_cnt = r_u_cnt + CW'(1);
                            n_rsp.region_address = {f_rd.base_pg, 12'h000};
                            if (rem == '0) begin
                                // slot emptied: pull the last entry into it
                                n_f_cnt = r_f_cnt - CW'(1);
                                f_ra    = n_f_cnt[IW-1:0];
                                n_state = S_MOVE;
                            end else begin
                                f_we = 1'b1;
                                f_wd.base_pg = f_rd.base_pg + r_pages[19:0];
                                f_wd.page_total = rem;
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (u_rd.base_pg == r_sp) begin
                        if (r_f_cnt >= SLOTS) begin
                            n_rsp.status = ST_FULL;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            f_we = 1'b1;
                            f_wa = r_f_cnt[IW-1:0];
                            f_wd = u_rd;
                            n_f_cnt = r_f_cnt + CW'(1);
                            n_u_cnt = r_u_cnt - CW'(1);
                            u_ra    = n_u_cnt[IW-1:0];
                            n_rsp.freed_first_page = u_rd.base_pg;
                            n_rsp.freed_page_count = u_rd.page_total;
                            n_state = S_MOVE;
                        end
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_MOVE: begin
                if (r_kind == KIND_ALLOC) begin
                    f_we = 1'b1;
                    f_wd = f_rd;
                end else begin
                    u_we = 1'b1;
                    u_wd = u_rd;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `FFPRA_ASSERT_NOW(a_free_cnt_range, i_clk, i_rst_n, 1'b1, r_f_cnt <= SLOTS, "free count overflow")
    `FFPRA_ASSERT_NOW(a_used_cnt_range, i_clk, i_rst_n, 1'b1, r_u_cnt <= SLOTS, "used count overflow")
    `FFPRA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "done held two cycles")
    `FFPRA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted word did not start work")
endmodule

>>> dv/first_fit_page_region_allocator_top_test.sv
// Self-checking testbench for the first-fit page region allocator.
// Depends on ffpra_pkg and first_fit_page_region_allocator_top.
`timescale 1ns / 1ps

module first_fit_page_region_allocator_top_test;
    import ffpra_pkg::*;

    localparam int SLOTS = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    first_fit_page_region_allocator_top #(.REGION_SLOTS(SLOTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the allocator: pool registers and both region tables.
    logic [31:0] pool_base, pool_bytes;
    logic [19:0] free_sp [SLOTS];
    logic [20:0] free_pt [SLOTS];
    logic [19:0] used_sp [SLOTS];
    logic [20:0] used_pt [SLOTS];
    int          free_cnt, used_cnt;

    t_req pending_words [$];
    t_rsp expected_rsps [$];
    int   errors = 0;
    int   done_cnt = 0;
    int   alloc_ok = 0, release_ok = 0, full_hits = 0;
    bit   no_gaps = 1'b0;

    function automatic void rebuild_pool();
        logic [19:0] bp;
        logic [31:0] pages;
        bp = pool_base[31:12];
        pages = pool_bytes >> 12;
        used_sp[0] = bp;
        used_pt[0] = 21'd1;
        used_cnt = 1;
        if (pages >= 2) begin
            free_sp[0] = bp + 20'd1;
            free_pt[0] = 21'(pages - 1);
            free_cnt = 1;
        end else begin
            free_cnt = 0;
        end
    endfunction

    function automatic void rebuild_pool_reset();
        pool_base = 32'h4000_0000;
        pool_bytes = 32'h0040_0000;
        rebuild_pool();
    endfunction

    // Applies one request word to the shadow tables and returns its result.
    function automatic t_rsp apply_request(t_req w);
        t_rsp r;
        logic [32:0] pages;
        logic [19:0] sp;
        logic [20:0] n;
        logic [32:0] hi;
        r = '0;
        r.status = ST_OK;
        case (w.kind)
            KIND_ALLOC: begin
                pages = ({1'b0, w.request_bytes} + PAGE_ROUND) >> 12;
                r.status = ST_NO_FIT;
                for (int i = 0; i < free_cnt; i++) begin
                    if ({12'd0, free_pt[i]} >= pages) begin
                        sp = free_sp[i];
                        if (used_cnt >= SLOTS) begin
                            r.status = ST_FULL;
                            break;
                        end
                        used_sp[used_cnt] = sp;
                        used_pt[used_cnt] = pages[20:0];
                        used_cnt++;
                        free_sp[i] = sp + pages[19:0];
                        free_pt[i] = free_pt[i] - pages[20:0];
                        if (free_pt[i] == 0) begin
                            free_cnt--;
                            free_sp[i] = free_sp[free_cnt];
                            free_pt[i] = free_pt[free_cnt];
                        end
                        r.region_address = {sp, 12'd0};
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            KIND_RELEASE: begin
                sp = w.address[31:12];
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < used_cnt; i++) begin
                    if (used_sp[i] == sp) begin
                        n = used_pt[i];
                        if (free_cnt >= SLOTS) begin
                            r.status = ST_FULL;
                            break;
                        end
                        free_sp[free_cnt] = sp;
                        free_pt[free_cnt] = n;
                        free_cnt++;
                        used_cnt--;
                        used_sp[i] = used_sp[used_cnt];
                        used_pt[i] = used_pt[used_cnt];
                        r.freed_first_page = sp;
                        r.freed_page_count = n;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            KIND_CHECK: begin
                hi = {1'b0, pool_base} + {1'b0, pool_bytes};
                r.legitimate = ({1'b0, w.address} >= {1'b0, pool_base})
                    && ({1'b0, w.address} < hi);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: one word at a time, random gaps between words unless no_gaps is set.
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            // word accepted this edge
            expected_rsps.push_back(apply_request(i_req));
            if (pending_words.size() > 0 && no_gaps) begin
                i_req <= pending_words.pop_front();
            end else begin
                start <= 1'b0;
                gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0);
            end
        end else if (!start) begin
            if (gap > 0) begin
                gap--;
            end else if (pending_words.size() > 0) begin
                i_req <= pending_words.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: every strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_done) begin
            done_cnt++;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_rsp);
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                if (o_rsp.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_rsp.status);
                    errors++;
                end
                if (o_rsp.region_address !== e.region_address) begin
                    $display("%0t: region_address exp %h got %h", $time,
                        e.region_address, o_rsp.region_address);
                    errors++;
                end
                if (o_rsp.freed_first_page !== e.freed_first_page) begin
                    $display("%0t: freed_first_page exp %h got %h", $time,
                        e.freed_first_page, o_rsp.freed_first_page);
                    errors++;
                end
                if (o_rsp.freed_page_count !== e.freed_page_count) begin
                    $display("%0t: freed_page_count exp %h got %h", $time,
                        e.freed_page_count, o_rsp.freed_page_count);
                    errors++;
                end
                if (o_rsp.legitimate !== e.legitimate) begin
                    $display("%0t: legitimate exp %0b got %0b", $time,
                        e.legitimate, o_rsp.legitimate);
                    errors++;
                end
                if (e.status == ST_FULL) full_hits++;
                if (e.status == ST_OK && e.region_address != 0) alloc_ok++;
                if (e.status == ST_OK && e.freed_page_count != 0) release_ok++;
            end
        end
    end

    // Live allocations seen by the stimulus, so releases mostly hit.
    logic [31:0] live_addrs [$];

    function automatic t_req mk(t_kind k, logic [31:0] b, logic [31:0] a);
        t_req w;
        w.kind = k;
        w.request_bytes = b;
        w.address = a;
        return w;
    endfunction

    // Waits until every queued word is accepted and answered, then for the
    // block's worst latency so nothing is still in flight.
    task automatic drain();
        while (pending_words.size() > 0 || start || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (2 * SLOTS + 10) @(posedge i_clk);
    endtask

    // Lets queued words finish, then harvests addresses of live regions.
    task automatic drain_light();
        while (pending_words.size() > 0 || start || expected_rsps.size() > 0)
            @(posedge i_clk);
        live_addrs.delete();
        for (int i = 1; i < used_cnt; i++) live_addrs.push_back({used_sp[i], 12'd0});
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POOL_BASE) pool_base = val; else pool_bytes = val;
        rebuild_pool();
        live_addrs.delete();
        repeat (3) @(posedge i_clk);
    endtask

    // Random phase: mostly well-formed alloc/release with random sizes.
    task automatic random_phase(int n, int max_pages);
        t_req w;
        int k;
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                a = $urandom_range(0, max_pages * 4096);
                if ($urandom_range(0, 19) == 0) a = $urandom;
                w = mk(KIND_ALLOC, a, $urandom);
            end else if (k < 80 && live_addrs.size() > 0) begin
                int j;
                j = $urandom_range(0, live_addrs.size() - 1);
                a = live_addrs[j] | $urandom_range(0, 4095);
                live_addrs.delete(j);
                w = mk(KIND_RELEASE, $urandom, a);
            end else if (k < 85) begin
                w = mk(KIND_RELEASE, $urandom, $urandom);
            end else if (k < 97) begin
                a = ($urandom_range(0, 1)) ? $urandom
                    : pool_base + $urandom_range(0, 1) * pool_bytes - $urandom_range(0, 1);
                w = mk(KIND_CHECK, $urandom, a);
            end else begin
                w = mk(KIND_NONE, $urandom, $urandom);
            end
            pending_words.push_back(w);
            // Keep a rough guess of what got allocated: predicted addresses are
            // known only after acceptance, so sync every few words.
            if (i % 8 == 7) begin
                drain_light();
            end
        end
    endtask

    initial begin
        rebuild_pool_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: zero bytes, one byte, exact page, too big, max bytes,
        // release of base page, release not found, check bounds, unused kind.
        pending_words.push_back(mk(KIND_ALLOC, 32'd0, 32'd0));
        pending_words.push_back(mk(KIND_ALLOC, 32'd1, 32'hFFFFFFFF));
        pending_words.push_back(mk(KIND_ALLOC, 32'd4096, 32'd0));
        pending_words.push_back(mk(KIND_ALLOC, 32'd4097, 32'd0));
        pending_words.push_back(mk(KIND_ALLOC, 32'hFFFFFFFF, 32'd0));
        pending_words.push_back(mk(KIND_ALLOC, 32'h0040_0000, 32'd0));
        pending_words.push_back(mk(KIND_RELEASE, 32'd0, 32'h4000_0FFF));
        pending_words.push_back(mk(KIND_RELEASE, 32'hFFFFFFFF, 32'h4000_1000));
        pending_words.push_back(mk(KIND_RELEASE, 32'd0, 32'h1234_5000));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'h3FFF_FFFF));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'h4000_0000));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'h403F_FFFF));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'h4040_0000));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'hFFFFFFFF));
        pending_words.push_back(mk(KIND_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF));
        // Fill allocated table to hit table full on allocate.
        for (int i = 0; i < SLOTS + 1; i++)
            pending_words.push_back(mk(KIND_ALLOC, 32'd1, 32'd0));
        drain();

        // Tiny pool (under two pages, odd tail) and page wrap at the top.
        write_reg(CFG_POOL_BYTES, 32'd8191);
        pending_words.push_back(mk(KIND_ALLOC, 32'd0, 32'd0));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'h4000_1FFE));
        drain();
        write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
        write_reg(CFG_POOL_BYTES, 32'd8192);
        pending_words.push_back(mk(KIND_ALLOC, 32'd4096, 32'd0));
        pending_words.push_back(mk(KIND_RELEASE, 32'd0, 32'h0000_0000));
        pending_words.push_back(mk(KIND_CHECK, 32'd0, 32'hFFFF_FFFF));
        drain();

        // Random phases over several pool settings, extremes among them.
        write_reg(CFG_POOL_BASE, 32'h0000_0000);
        write_reg(CFG_POOL_BYTES, 32'h8000_0000);
        random_phase(250, 8);
        drain();
        write_reg(CFG_POOL_BASE, 32'h4000_0000);
        write_reg(CFG_POOL_BYTES, 32'h0004_0000);
        random_phase(350, 6);
        drain();
        write_reg(CFG_POOL_BASE, 32'hFFF0_0000);
        write_reg(CFG_POOL_BYTES, 32'h0020_0000);
        random_phase(300, 3);
        drain();
        write_reg(CFG_POOL_BASE, 32'h1234_5000);
        write_reg(CFG_POOL_BYTES, 32'h0000_4000);
        random_phase(150, 2);
        drain();
        // Last stretch: back-to-back words, no idling.
        no_gaps = 1'b1;
        write_reg(CFG_POOL_BASE, 32'h8000_0000);
        write_reg(CFG_POOL_BYTES, 32'h0010_0000);
        random_phase(300, 4);
        drain();

        $display("Covered %0d results: %0d allocs, %0d releases, %0d table-full hits,",
            done_cnt, alloc_ok, release_ok, full_hits);
        $display("over several pool settings including tiny, wrapping and 2 GiB pools.");
        if (errors == 0) begin
            $display("PASS first_fit_page_region_allocator_top");
        end else begin
            $display("FAIL first_fit_page_region_allocator_top");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL first_fit_page_region_allocator_top");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/ffpra_pkg.sv
src/ffpra_ram.sv
src/first_fit_page_region_allocator_top.sv
dv/first_fit_page_region_allocator_top_test.sv
